// ===== rtl/core/ic_pkg.sv =====
// ----------------------------------------------------------------------------
// ic_pkg
// Shared types and constants of the inversion counter.
// ----------------------------------------------------------------------------
package ic_pkg;

  localparam int MAX_ITEMS_DEFAULT = 1024;
  localparam int VALUE_W           = 32;
  localparam int COUNT_W           = 19;

  localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic valid;
    logic drop;
    logic last;
  } tok_ctrl_t;

endpackage

// ===== rtl/core/ic_in_if.sv =====
// ----------------------------------------------------------------------------
// ic_in_if
// Input channel: one sequence element per transaction.
// ----------------------------------------------------------------------------
interface ic_in_if;
  import ic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] item_value;
  logic                      last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);

endinterface

// ===== rtl/core/ic_out_if.sv =====
// ----------------------------------------------------------------------------
// ic_out_if
// Result channel: one inversion total per sequence.
// ----------------------------------------------------------------------------
interface ic_out_if;
  import ic_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] inversion_count;
  logic               overflow;

  modport source (output valid, output inversion_count, output overflow, input ready);
  modport sink   (input valid, input inversion_count, input overflow, output ready);

endinterface

// ===== rtl/core/ic_cell.sv =====
// ----------------------------------------------------------------------------
// ic_cell
// One slot of the chain: holds one stored value, counts a passing key
// against it and forwards the token to the next slot.
// ----------------------------------------------------------------------------
module ic_cell #(
  parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEFAULT,
  parameter int POS       = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  ic_pkg::tok_ctrl_t                 ctrl_in,
  input  logic [$clog2(MAX_ITEMS)-1:0]      idx_in,
  input  logic signed [ic_pkg::VALUE_W-1:0] key_in,
  input  logic [$clog2(MAX_ITEMS)-1:0]      cnt_in,
  output ic_pkg::tok_ctrl_t                 ctrl_out,
  output logic [$clog2(MAX_ITEMS)-1:0]      idx_out,
  output logic signed [ic_pkg::VALUE_W-1:0] key_out,
  output logic [$clog2(MAX_ITEMS)-1:0]      cnt_out
);
  import ic_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam logic [IW-1:0] MY_POS = IW'(POS);

  logic signed [VALUE_W-1:0] value;
  logic                      live;
  logic                      hit;
  logic                      store;

  assign live  = ctrl_in.valid && !ctrl_in.drop;
  assign hit   = live && (MY_POS < idx_in) && (value > key_in);
  assign store = live && (idx_in == MY_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_out <= idx_in;
      key_out <= key_in;
      cnt_out <= cnt_in + IW'(hit);
    end
    if (adv && store) begin
      value <= key_in;
    end
  end

endmodule

// ===== rtl/core/ic_tail.sv =====
// ----------------------------------------------------------------------------
// ic_tail
// End of the chain: accumulates per-item counts into a saturating total and
// holds the result register of the output channel.
// ----------------------------------------------------------------------------
module ic_tail #(
  parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ic_pkg::tok_ctrl_t            ctrl_in,
  input  logic [$clog2(MAX_ITEMS)-1:0] cnt_in,
  output logic                         adv,
  ic_out_if.source                     results
);
  import ic_pkg::*;

  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int SUM_W = ((IW > COUNT_W) ? IW : COUNT_W) + 1;

  logic [COUNT_W-1:0] total;
  logic               ovf_seen;
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               res_ovf;

  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] total_next;
  logic               ovf_next;

  assign adv = !res_valid || results.ready;

  always_comb begin
    sum = SUM_W'(total) + SUM_W'(cnt_in);
    if (ctrl_in.drop) begin
      total_next = total;
    end else if (sum > SUM_W'(TOTAL_MAX)) begin
      total_next = TOTAL_MAX;
    end else begin
      total_next = sum[COUNT_W-1:0];
    end
    ovf_next = ovf_seen || ctrl_in.drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      ovf_seen  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      if (adv && ctrl_in.valid) begin
        if (ctrl_in.last) begin
          total     <= '0;
          ovf_seen  <= 1'b0;
          res_valid <= 1'b1;
        end else begin
          total    <= total_next;
          ovf_seen <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctrl_in.valid && ctrl_in.last) begin
      res_count <= total_next;
      res_ovf   <= ovf_next;
    end
  end

  assign results.valid           = res_valid;
  assign results.inversion_count = res_count;
  assign results.overflow        = res_ovf;

endmodule

// ===== rtl/core/inversion_counter.sv =====
// ----------------------------------------------------------------------------
// inversion_counter
// Counts inversions of a signed sequence with a chain of compare cells.
// ----------------------------------------------------------------------------
// Each accepted value becomes a token that walks down a chain of MAX_ITEMS
// cells, one cell per cycle while the chain advances, counting the stored
// values of its sequence that are greater than it and leaving itself in the
// cell of its own position. A new item is taken every cycle while the chain
// advances; the result of a sequence enters the result register once its
// last item has passed the MAX_ITEMS cells. A result that is not taken holds
// the whole chain and the input. Items beyond MAX_ITEMS in one sequence are
// dropped and flag overflow; the total saturates at the largest result value.
module inversion_counter #(
  parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  ic_in_if.sink  items,
  ic_out_if.source results
);
  import ic_pkg::*;

  localparam int IW   = $clog2(MAX_ITEMS);
  localparam int CNTW = $clog2(MAX_ITEMS + 1);

  logic            adv;
  logic [CNTW-1:0] fill;
  logic            full;
  logic            accept;

  tok_ctrl_t                 ctrl_s [0:MAX_ITEMS];
  logic [IW-1:0]             idx_s  [0:MAX_ITEMS];
  logic signed [VALUE_W-1:0] key_s  [0:MAX_ITEMS];
  logic [IW-1:0]             cnt_s  [0:MAX_ITEMS];

  assign items.ready = adv;
  assign accept      = items.valid && adv;
  assign full        = (fill == CNTW'(MAX_ITEMS));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      if (items.last_item) begin
        fill <= '0;
      end else if (!full) begin
        fill <= fill + CNTW'(1);
      end
    end
  end

  assign ctrl_s[0].valid = items.valid;
  assign ctrl_s[0].drop  = full;
  assign ctrl_s[0].last  = items.last_item;
  assign idx_s[0]        = fill[IW-1:0];
  assign key_s[0]        = items.item_value;
  assign cnt_s[0]        = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    ic_cell #(
      .MAX_ITEMS (MAX_ITEMS),
      .POS       (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctrl_in  (ctrl_s[g]),
      .idx_in   (idx_s[g]),
      .key_in   (key_s[g]),
      .cnt_in   (cnt_s[g]),
      .ctrl_out (ctrl_s[g+1]),
      .idx_out  (idx_s[g+1]),
      .key_out  (key_s[g+1]),
      .cnt_out  (cnt_s[g+1])
    );
  end

  ic_tail #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_tail (
    .clk     (clk),
    .rst     (rst),
    .ctrl_in (ctrl_s[MAX_ITEMS]),
    .cnt_in  (cnt_s[MAX_ITEMS]),
    .adv     (adv),
    .results (results)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNTW'(MAX_ITEMS))
    else $error("fill count above capacity");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |->
      $past(adv && ctrl_s[MAX_ITEMS].valid && ctrl_s[MAX_ITEMS].last))
    else $error("result without a last transaction at the chain end");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (accept && !full) |=> !ctrl_s[1].drop)
    else $error("item dropped below capacity");

endmodule
